/* rtl/rkbc_pkg.sv */
`default_nettype none

package rkbc_pkg;

  // Pad geometry.
  localparam int PAD_ENTRIES = 2500;
  localparam int PadAddrW = (PAD_ENTRIES > 1) ? $clog2(PAD_ENTRIES) : 1;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QueuePtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QueueCntW = $clog2(QUEUE_DEPTH + 1);

  // Command codes. The same codes tag the entries in the queue.
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ENCRYPT = 2'd1,
    CMD_DECRYPT = 2'd2
  } cmd_t;

  // Input beat.
  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] pad_index;
    logic [7:0]  data_byte;
  } rkbc_in_t;

  // Result beat.
  typedef struct packed {
    logic [7:0] result_byte;
    logic       message_end;
  } rkbc_out_t;

  // One classified operation waiting for the back.
  typedef struct packed {
    cmd_t                kind;
    logic [PadAddrW-1:0] addr;
    logic [7:0]          data;
  } rkbc_entry_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } rkbc_qstat_t;

endpackage

`default_nettype wire

/* rtl/rkbc_ram.sv */
`default_nettype none

module rkbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2500
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Read data holds while no read is issued.
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/rkbc_fifo.sv */
`default_nettype none

module rkbc_fifo
  import rkbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire rkbc_entry_t push_entry,
  input  wire logic        pop,
  output rkbc_entry_t      pop_entry,
  output rkbc_qstat_t      status
);

  rkbc_entry_t            slots [QUEUE_DEPTH];
  logic [QueuePtrW-1:0]   wr_ptr;
  logic [QueuePtrW-1:0]   rd_ptr;
  logic [QueueCntW-1:0]   count;

  assign status.full  = (count == QueueCntW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_entry    = slots[rd_ptr];

  function automatic logic [QueuePtrW-1:0] bump(input logic [QueuePtrW-1:0] p);
    bump = (p == QueuePtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    status.empty |-> !pop)
    else $error("queue read while empty");

endmodule

`default_nettype wire

/* rtl/rkbc_front.sv */
`default_nettype none

module rkbc_front
  import rkbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire rkbc_in_t    item,
  input  wire rkbc_qstat_t qstat,
  output logic             push,
  output rkbc_entry_t      push_entry
);

  logic [PadAddrW-1:0] pad_position;
  logic [PadAddrW-1:0] pad_position_next;
  logic                accept;
  logic                keep;

  assign item_stall = qstat.full;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    keep              = 1'b0;
    pad_position_next = pad_position;
    push_entry.kind   = CMD_LOAD;
    push_entry.addr   = pad_position;
    push_entry.data   = item.data_byte;
    case (cmd_t'(item.command))
      CMD_LOAD: begin
        // Writes beyond the pad are dropped here.
        keep            = (32'(item.pad_index) < PAD_ENTRIES);
        push_entry.kind = CMD_LOAD;
        push_entry.addr = item.pad_index[PadAddrW-1:0];
      end
      CMD_ENCRYPT, CMD_DECRYPT: begin
        keep            = 1'b1;
        push_entry.kind = cmd_t'(item.command);
        if (item.data_byte == 8'd0) begin
          pad_position_next = '0;
        end else if (pad_position == PadAddrW'(PAD_ENTRIES - 1)) begin
          pad_position_next = '0;
        end else begin
          pad_position_next = pad_position + 1'b1;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_position <= '0;
    end else if (accept) begin
      pad_position <= pad_position_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/rkbc_back.sv */
`default_nettype none

module rkbc_back
  import rkbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rkbc_qstat_t qstat,
  input  wire rkbc_entry_t pop_entry,
  output logic             pop,
  output logic             result_valid,
  input  wire logic        result_stall,
  output rkbc_out_t        result
);

  logic       is_load;
  logic       out_free;
  logic       s1_valid;
  logic       s1_decrypt;
  logic [7:0] s1_data;
  logic       s1_move;
  logic       s1_ready;
  logic       issue;
  logic [7:0] key;
  logic [8:0] sum;
  logic [7:0] diff;
  logic [7:0] cipher;

  assign is_load  = (pop_entry.kind == CMD_LOAD);
  assign out_free = !result_valid || !result_stall;
  assign s1_move  = s1_valid && out_free;
  assign s1_ready = !s1_valid || s1_move;
  assign pop      = !qstat.empty && (is_load || s1_ready);
  assign issue    = pop && !is_load;

  rkbc_ram #(
    .WIDTH (8),
    .DEPTH (PAD_ENTRIES)
  ) u_pad (
    .clk   (clk),
    .we    (pop && is_load),
    .waddr (pop_entry.addr),
    .wdata (pop_entry.data),
    .re    (issue),
    .raddr (pop_entry.addr),
    .rdata (key)
  );

  always_comb begin
    sum  = {1'b0, s1_data} + {1'b0, key};
    diff = s1_data - key;
    if (s1_decrypt) begin
      cipher = ((key != 8'd0) && (s1_data <= key)) ? diff - 8'd1 : diff;
    end else begin
      cipher = sum[8] ? sum[7:0] + 8'd1 : sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= issue;
      end
      if (out_free) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_decrypt <= (pop_entry.kind == CMD_DECRYPT);
      s1_data    <= pop_entry.data;
    end
    if (s1_move) begin
      result.message_end <= (s1_data == 8'd0);
      result.result_byte <= (s1_data == 8'd0) ? 8'd0 : cipher;
    end
  end

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_data))
    else $error("cipher stage lost its byte while the result was stalled");

  a_end_marker: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) && result.message_end |-> result.result_byte == 8'd0)
    else $error("message end carries a nonzero byte");

endmodule

`default_nettype wire

/* rtl/running_key_byte_cipher.sv */
// Path: a text byte accepted at the input passes through the queue, the pad read
// stage and the result register before its result shows; load beats give no result.
// Throughput: one beat per cycle sustained while the result is not stalled; the
// back takes one queue entry each cycle, a load write or a key read of the pad.
// Reset (rst, synchronous, active high) empties the queue and pipeline and sets
// the pad position to zero; pad contents are undefined until loaded.
`default_nettype none

module running_key_byte_cipher
  import rkbc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_stall,
  input  wire rkbc_in_t item,
  output logic          result_valid,
  input  wire logic     result_stall,
  output rkbc_out_t     result
);

  // The front tracks the pad position and sorts beats into queue entries.
  // Load beats with an index past the pad and unused commands are dropped
  // there, so only real work enters the queue.
  rkbc_qstat_t qstat;
  rkbc_entry_t push_entry;
  rkbc_entry_t pop_entry;
  logic        push;
  logic        pop;

  rkbc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  // A two-entry queue decouples the front from the back so that a stalled
  // result does not stop the input side at once.
  rkbc_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .status     (qstat)
  );

  // The back owns the pad memory. Loads and key reads both go through it in
  // queue order, so a key byte loaded just before a text byte is seen by it.
  rkbc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .pop_entry    (pop_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
